@@ sv/tpld_pkg.sv @@
// ----------------------------------------------------------------------------
// tpld_pkg
// Shared constants, result codes and the front-to-back command word for the
// tracker peer list dedup block.
// ----------------------------------------------------------------------------
package tpld_pkg;

  localparam int unsigned TABLE_DEPTH  = 1024;
  localparam int unsigned HEADER_BYTES = 20;
  localparam int unsigned RECORD_BYTES = 6;

  localparam int unsigned POS_W = 17;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned KEY_W = 48;

  localparam logic [31:0]      ERROR_ACTION = 32'd3;
  localparam logic [POS_W-1:0] POS_MAX      = '1;
  localparam logic [POS_W-1:0] ACTION_END   = POS_W'(4);
  localparam logic [POS_W-1:0] HEADER_POS   = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] MIN_PEER_POS = POS_W'(HEADER_BYTES + RECORD_BYTES);
  localparam logic [2:0]       FILL_LAST    = 3'(RECORD_BYTES - 1);
  localparam logic [CNT_W-1:0] TABLE_FULL   = CNT_W'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    KIND_SAVED = 3'd0,
    KIND_DUP   = 3'd1,
    KIND_FULL  = 3'd2,
    KIND_DONE  = 3'd3,
    KIND_ERROR = 3'd4,
    KIND_EMPTY = 3'd5
  } kind_e;

  // one command per byte that produces results
  typedef struct packed {
    logic              has_rec;
    logic [KEY_W-1:0]  key;
    logic              has_sum;
    kind_e             sum_kind;
  } cmd_t;

endpackage

@@ sv/tpld_front.sv @@
// ----------------------------------------------------------------------------
// tpld_front
// Byte parser: tracks position, action word and record assembly, and turns
// each byte that completes a record or closes a packet into a command.
// ----------------------------------------------------------------------------
module tpld_front import tpld_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       q_full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic [POS_W-1:0] pos_q, pos_d, pos_inc;
  logic [31:0]      action_q, action_d;
  logic [KEY_W-1:0] shift_q, shift_d, shift_n;
  logic [2:0]       fill_q, fill_d;
  logic             accept, in_rec, rec_done;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign pos_inc  = (pos_q == POS_MAX) ? pos_q : pos_q + POS_W'(1);
  // action word is complete before the header ends
  assign in_rec   = (pos_q >= HEADER_POS) && (action_q != ERROR_ACTION);
  assign shift_n  = {shift_q[KEY_W-9:0], data_byte_i};
  assign rec_done = in_rec && (fill_q == FILL_LAST);

  always_comb begin
    action_d = action_q;
    if (pos_q < ACTION_END) begin
      case (pos_q[1:0])
        2'd0:    action_d = action_q | {data_byte_i, 24'd0};
        2'd1:    action_d = action_q | {8'd0, data_byte_i, 16'd0};
        2'd2:    action_d = action_q | {16'd0, data_byte_i, 8'd0};
        default: action_d = action_q | {24'd0, data_byte_i};
      endcase
    end
  end

  always_comb begin
    cmd_o.has_rec = rec_done;
    cmd_o.key     = shift_n;
    cmd_o.has_sum = last_byte_i;
    if (action_d == ERROR_ACTION) begin
      cmd_o.sum_kind = KIND_ERROR;
    end else if (pos_inc < MIN_PEER_POS) begin
      cmd_o.sum_kind = KIND_EMPTY;
    end else begin
      cmd_o.sum_kind = KIND_DONE;
    end
  end

  assign push_o = accept && (rec_done || last_byte_i);

  always_comb begin
    pos_d   = pos_inc;
    shift_d = shift_q;
    fill_d  = fill_q;
    if (in_rec) begin
      shift_d = rec_done ? '0 : shift_n;
      fill_d  = rec_done ? 3'd0 : fill_q + 3'd1;
    end
    if (last_byte_i) begin
      pos_d   = '0;
      shift_d = '0;
      fill_d  = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      action_q <= '0;
      shift_q  <= '0;
      fill_q   <= 3'd0;
    end else if (accept) begin
      pos_q    <= pos_d;
      action_q <= last_byte_i ? '0 : action_d;
      shift_q  <= shift_d;
      fill_q   <= fill_d;
    end
  end

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_LAST) else $error("record fill out of range");

  a_fill_after_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != 3'd0) |-> (pos_q > HEADER_POS)) else $error("record bytes inside header");

endmodule

@@ sv/tpld_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// tpld_cmd_fifo
// Two-entry command queue between the parser and the table engine.
// ----------------------------------------------------------------------------
module tpld_cmd_fifo import tpld_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ sv/tpld_back.sv @@
// ----------------------------------------------------------------------------
// tpld_back
// Table engine: searches the peer table one entry a cycle, appends new
// peers and drives the registered result word.
// ----------------------------------------------------------------------------
module tpld_back import tpld_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  cmd_t        head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [31:0] peer_ip_o,
  output logic [15:0] peer_port_o,
  output logic [10:0] peer_total_o,
  output logic        run_end_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_REC,
    ST_SUM
  } state_e;

  state_e           state_q;
  cmd_t             cmd_q;
  kind_e            res_kind_q;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] rd_idx_q;
  logic             cmp_vld_q;
  logic [KEY_W-1:0] rd_data_q;
  logic [KEY_W-1:0] table_mem [TABLE_DEPTH];

  logic             out_valid_q, out_end_q;
  kind_e            out_kind_q;
  logic [31:0]      out_ip_q;
  logic [15:0]      out_port_q;
  logic [CNT_W-1:0] out_total_q;

  logic             slot_free, out_load, hit, last_cmp, wr_en;
  logic [KEY_W-1:0] wr_key;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign out_load  = slot_free && (state_q == ST_REC || state_q == ST_SUM);
  assign pop_o     = (state_q == ST_IDLE) && !q_empty_i;
  assign hit       = cmp_vld_q && (rd_data_q == cmd_q.key);
  // rd_data_q holds the entry just below rd_idx_q
  assign last_cmp  = cmp_vld_q && (rd_idx_q == count_q);

  always_comb begin
    wr_en  = 1'b0;
    wr_key = cmd_q.key;
    if (pop_o && head_i.has_rec && count_q == '0) begin
      wr_en  = 1'b1;
      wr_key = head_i.key;
    end else if (state_q == ST_SEARCH && !hit && last_cmp) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[count_q[IDX_W-1:0]] <= wr_key;
    end
    rd_data_q <= table_mem[rd_idx_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '0;
      res_kind_q  <= KIND_SAVED;
      count_q     <= '0;
      rd_idx_q    <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_kind_q  <= KIND_SAVED;
      out_ip_q    <= '0;
      out_port_q  <= '0;
      out_total_q <= '0;
      out_end_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (wr_en) begin
        count_q <= count_q + CNT_W'(1);
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            cmd_q     <= head_i;
            rd_idx_q  <= '0;
            cmp_vld_q <= 1'b0;
            if (!head_i.has_rec) begin
              state_q <= ST_SUM;
            end else if (count_q == TABLE_FULL) begin
              res_kind_q <= KIND_FULL;
              state_q    <= ST_REC;
            end else if (count_q == '0) begin
              res_kind_q <= KIND_SAVED;
              state_q    <= ST_REC;
            end else begin
              state_q <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (hit) begin
            res_kind_q <= KIND_DUP;
            cmp_vld_q  <= 1'b0;
            state_q    <= ST_REC;
          end else if (last_cmp) begin
            res_kind_q <= KIND_SAVED;
            cmp_vld_q  <= 1'b0;
            state_q    <= ST_REC;
          end else begin
            cmp_vld_q <= (rd_idx_q < count_q);
            if (rd_idx_q < count_q) begin
              rd_idx_q <= rd_idx_q + CNT_W'(1);
            end
          end
        end
        ST_REC: begin
          if (slot_free) begin
            out_kind_q  <= res_kind_q;
            out_ip_q    <= cmd_q.key[KEY_W-1:16];
            out_port_q  <= cmd_q.key[15:0];
            out_total_q <= count_q;
            out_end_q   <= !cmd_q.has_sum;
            state_q     <= cmd_q.has_sum ? ST_SUM : ST_IDLE;
          end
        end
        ST_SUM: begin
          if (slot_free) begin
            out_kind_q  <= cmd_q.sum_kind;
            out_ip_q    <= '0;
            out_port_q  <= '0;
            out_total_q <= count_q;
            out_end_q   <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_kind_q;
  assign peer_ip_o    = out_ip_q;
  assign peer_port_o  = out_port_q;
  assign peer_total_o = 11'(out_total_q);
  assign run_end_o    = out_end_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= TABLE_FULL) else $error("peer count beyond table depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1)))
    else $error("peer count jumped");

  a_cmp_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (state_q == ST_SEARCH)) else $error("compare outside search");

endmodule

@@ sv/tracker_peer_list_dedup.sv @@
// ----------------------------------------------------------------------------
// tracker_peer_list_dedup
// Announce response parser with a table of unique peers kept across packets.
// ----------------------------------------------------------------------------
//  channel | signals                                     | dir
//  --------+---------------------------------------------+-----
//  in      | in_valid_i, in_stall_o, data_byte_i,        | in
//          | last_byte_i                                 |
//  out     | out_valid_o, out_stall_i, kind_o, peer_ip_o,| out
//          | peer_port_o, peer_total_o, run_end_o        |
//
// a byte that yields no result only updates the parser registers
// a completed record is checked against the table one entry per cycle, as the
// table has a single read port
// a two-word command queue lets the parser keep taking bytes meanwhile
// reset clears counters and state; table contents are only read below count
// out_stall_i holds the result register, the queue then fills and stalls in
// ----------------------------------------------------------------------------
module tracker_peer_list_dedup import tpld_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [31:0] peer_ip_o,
  output logic [15:0] peer_port_o,
  output logic [10:0] peer_total_o,
  output logic        run_end_o
);

  cmd_t push_cmd, head_cmd;
  logic push, pop, q_full, q_empty;

  tpld_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  tpld_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .head_o  (head_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  tpld_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .peer_ip_o    (peer_ip_o),
    .peer_port_o  (peer_port_o),
    .peer_total_o (peer_total_o),
    .run_end_o    (run_end_o)
  );

endmodule
